// ===== hw/rtl/psched_pkg.sv =====
// Shared constants and controller/datapath interface types of the stride scheduler.
package psched_pkg;

  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned SLOT_FIELD_W     = 3;
  localparam int unsigned PASS_W           = 48;
  localparam int unsigned IDX_EXT_W        = 7;
  localparam int unsigned STRIDE_NUMERATOR = 10000;
  localparam int unsigned NUMERATOR_W      = 14;
  localparam int unsigned S_TDATA_W        = 56;
  localparam int unsigned M_TDATA_W        = 56;

  localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_write;
    logic scan_step;
    logic final_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
  } status_t;

endpackage

// ===== hw/rtl/psched_div.sv =====
// Restoring divider: constant numerator scaled by the fraction bits over a 16-bit weight.
module psched_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [psched_pkg::FIELD_W-1:0]               divisor_i,
  output logic [psched_pkg::NUMERATOR_W+FRAC_BITS-1:0] quotient_o,
  output logic                                         done_o
);

  localparam int unsigned NUM_W = psched_pkg::NUMERATOR_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] NUMERATOR =
    NUM_W'(psched_pkg::STRIDE_NUMERATOR) << FRAC_BITS;

  logic                               busy_q;
  logic                               done_q;
  logic [CNT_W-1:0]                   cnt_q;
  logic [NUM_W-1:0]                   num_q;
  logic [NUM_W-1:0]                   quo_q;
  logic [psched_pkg::FIELD_W-1:0]     rem_q;
  logic [psched_pkg::FIELD_W-1:0]     div_q;
  logic [psched_pkg::FIELD_W:0]       rem_sh;
  logic [psched_pkg::FIELD_W:0]       rem_sub;
  logic                               fits;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, most significant first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NUMERATOR;
      quo_q <= '0;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_sub[psched_pkg::FIELD_W-1:0] : rem_sh[psched_pkg::FIELD_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== hw/rtl/psched_datapath.sv =====
// Slot store, release and minimum-pass scan, pass update and stride division.
module psched_datapath #(
  parameter int unsigned TASK_SLOTS           = 8,
  parameter int unsigned STRIDE_FRACTION_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  psched_pkg::cmd_t                      cmd_i,
  output psched_pkg::status_t                   status_o,
  input  logic                                  req_op_i,
  input  logic [psched_pkg::SLOT_FIELD_W-1:0]   req_slot_i,
  input  logic [psched_pkg::FIELD_W-1:0]        req_budget_i,
  input  logic [psched_pkg::FIELD_W-1:0]        req_period_i,
  input  logic [psched_pkg::FIELD_W-1:0]        req_weight_i,
  output logic                                  res_ran_o,
  output logic [psched_pkg::SLOT_FIELD_W-1:0]   res_slot_o,
  output logic [psched_pkg::PASS_W-1:0]         res_pass_o
);

  localparam int unsigned SLOT_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(TASK_SLOTS + 1);
  localparam int unsigned STRIDE_W = psched_pkg::NUMERATOR_W + STRIDE_FRACTION_BITS;
  localparam int unsigned FW       = psched_pkg::FIELD_W;
  localparam int unsigned PW       = psched_pkg::PASS_W;

  typedef struct packed {
    logic [FW-1:0]       budget;
    logic [FW-1:0]       period;
    logic [STRIDE_W-1:0] stride;
    logic [FW-1:0]       left;
    logic [FW-1:0]       phase;
    logic [PW-1:0]       pass;
  } entry_t;

  entry_t                          mem_q [TASK_SLOTS];
  entry_t                          rd_data_q;
  entry_t                          best_q;
  entry_t                          upd;
  entry_t                          fin;
  entry_t                          load_entry;
  entry_t                          wr_data;
  logic                            wr_en;
  logic [SLOT_W-1:0]               wr_addr;
  logic [SLOT_W-1:0]               rd_addr;
  logic                            rd_issue;

  logic [psched_pkg::SLOT_FIELD_W-1:0] slot_q;
  logic [FW-1:0]                   budget_q;
  logic [FW-1:0]                   period_q;
  logic [FW-1:0]                   weight_q;
  logic [TASK_SLOTS-1:0]           enabled_q;
  logic [CNT_W-1:0]                rd_idx_q;
  logic                            proc_valid_q;
  logic [SLOT_W-1:0]               proc_idx_q;
  logic                            best_valid_q;
  logic [SLOT_W-1:0]               best_idx_q;

  logic [psched_pkg::IDX_EXT_W-1:0] slot_ext;
  logic [psched_pkg::IDX_EXT_W-1:0] best_ext;
  logic [SLOT_W-1:0]               load_addr;
  logic                            in_range;
  logic                            tick_start;
  logic [STRIDE_W-1:0]             stride;
  logic                            div_done;
  logic                            cur_en;
  logic [FW:0]                     phase_inc;
  logic                            take;
  logic [PW:0]                     pass_sum;

  psched_div #(
    .FRAC_BITS (STRIDE_FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture && (req_op_i == psched_pkg::OP_LOAD)),
    .divisor_i  (req_weight_i),
    .quotient_o (stride),
    .done_o     (div_done)
  );

  assign tick_start = cmd_i.capture && (req_op_i == psched_pkg::OP_TICK);
  assign slot_ext   = psched_pkg::IDX_EXT_W'(slot_q);
  assign load_addr  = slot_ext[SLOT_W-1:0];
  assign in_range   = slot_ext < psched_pkg::IDX_EXT_W'(TASK_SLOTS);
  assign rd_issue   = cmd_i.scan_step && (rd_idx_q < CNT_W'(TASK_SLOTS));
  assign rd_addr    = rd_idx_q[SLOT_W-1:0];

  // release and phase advance of the entry under scan
  assign cur_en    = enabled_q[proc_idx_q];
  assign phase_inc = {1'b0, rd_data_q.phase} + (FW+1)'(1);

  always_comb begin
    upd = rd_data_q;
    if (rd_data_q.phase == '0) begin
      upd.left = rd_data_q.budget;
    end
    upd.phase = (phase_inc >= {1'b0, rd_data_q.period}) ? '0 : phase_inc[FW-1:0];
  end

  assign take = proc_valid_q && cur_en && (upd.left != '0) &&
                (!best_valid_q || (rd_data_q.pass < best_q.pass));

  // charge the winner: one budget unit and its stride, saturating
  assign pass_sum = {1'b0, best_q.pass} + (PW+1)'(best_q.stride);

  always_comb begin
    fin      = best_q;
    fin.left = best_q.left - FW'(1);
    fin.pass = (pass_sum >= {1'b0, psched_pkg::PASS_MAX}) ? psched_pkg::PASS_MAX
                                                          : pass_sum[PW-1:0];
  end

  always_comb begin
    load_entry        = '0;
    load_entry.budget = budget_q;
    load_entry.period = period_q;
    load_entry.stride = stride;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_q;
    wr_data = upd;
    priority if (cmd_i.load_write) begin
      wr_en   = in_range;
      wr_addr = load_addr;
      wr_data = load_entry;
    end else if (cmd_i.final_write) begin
      wr_en   = best_valid_q;
      wr_addr = best_idx_q;
      wr_data = fin;
    end else if (proc_valid_q && cur_en) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q   <= req_slot_i;
      budget_q <= req_budget_i;
      period_q <= req_period_i;
      weight_q <= req_weight_i;
    end
    if (take) begin
      best_q     <= upd;
      best_idx_q <= proc_idx_q;
    end
    if (rd_issue) begin
      proc_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= '0;
      rd_idx_q     <= '0;
      proc_valid_q <= 1'b0;
      best_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_write && in_range) begin
        enabled_q[load_addr] <= (weight_q != '0) && (period_q != '0);
      end
      if (tick_start) begin
        rd_idx_q     <= '0;
        proc_valid_q <= 1'b0;
        best_valid_q <= 1'b0;
      end else begin
        proc_valid_q <= rd_issue;
        if (rd_issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (take) begin
          best_valid_q <= 1'b1;
        end
      end
    end
  end

  assign best_ext   = psched_pkg::IDX_EXT_W'(best_idx_q);
  assign res_ran_o  = best_valid_q;
  assign res_slot_o = best_valid_q ? best_ext[psched_pkg::SLOT_FIELD_W-1:0] : '0;
  assign res_pass_o = best_valid_q ? best_q.pass : '0;

  assign status_o.div_done  = div_done;
  assign status_o.scan_last = proc_valid_q && (proc_idx_q == SLOT_W'(TASK_SLOTS - 1));

endmodule

// ===== hw/rtl/psched_ctrl.sv =====
// Sequencing state machine for load and tick requests.
module psched_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_op_i,
  input  logic                out_free_i,
  input  psched_pkg::status_t status_i,
  output psched_pkg::cmd_t    cmd_o,
  output logic                req_ready_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_FINAL
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            state_q <= (req_op_i == psched_pkg::OP_LOAD) ? ST_DIV : ST_SCAN;
          end
        end
        ST_DIV: begin
          if (status_i.div_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.capture     = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.load_write  = (state_q == ST_DIV) && status_i.div_done;
    cmd_o.scan_step   = (state_q == ST_SCAN);
    cmd_o.final_write = (state_q == ST_FINAL) && out_free_i;
    cmd_o.out_load    = (state_q == ST_FINAL) && out_free_i;
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

// ===== hw/rtl/periodic_stride_scheduler.sv =====
// Top level of the periodic stride scheduler: request and result channels.
// A tick result reaches the output register after the one-slot-a-cycle scan through the slot
// store, which reads one slot while it writes back another, and the next request is taken once
// that result is loaded. A load request is paced by the one-bit-a-cycle stride divider and
// gives no result.
// One request is worked on at a time; a finished result waits in the output register.
// Reset clears all enable bits and the control state; slot contents need no clearing.
module periodic_stride_scheduler #(
  parameter int unsigned TASK_SLOTS           = 8,
  parameter int unsigned STRIDE_FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, low bit up: slot_index[3], exec_budget[16], release_period[16],
  // share_weight[16], zero fill[5]
  input  logic [psched_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: op (0 tick, 1 load)
  input  logic                              s_axis_tuser,
  // result channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, low bit up: chosen_slot[3], chosen_pass[48], zero fill[5]
  output logic [psched_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: ran_task
  output logic                              m_axis_tuser
);

  localparam int unsigned FW = psched_pkg::FIELD_W;
  localparam int unsigned SW = psched_pkg::SLOT_FIELD_W;
  localparam int unsigned PW = psched_pkg::PASS_W;

  psched_pkg::cmd_t    cmd;
  psched_pkg::status_t status;

  logic [SW-1:0] req_slot;
  logic [FW-1:0] req_budget;
  logic [FW-1:0] req_period;
  logic [FW-1:0] req_weight;
  logic          res_ran;
  logic [SW-1:0] res_slot;
  logic [PW-1:0] res_pass;
  logic          out_free;

  logic          m_valid_q;
  logic          m_ran_q;
  logic [SW-1:0] m_slot_q;
  logic [PW-1:0] m_pass_q;

  // unpack the request fields
  assign req_slot   = s_axis_tdata[SW-1:0];
  assign req_budget = s_axis_tdata[SW+FW-1:SW];
  assign req_period = s_axis_tdata[SW+2*FW-1:SW+FW];
  assign req_weight = s_axis_tdata[SW+3*FW-1:SW+2*FW];

  // the output register may take a new result when empty or being drained
  assign out_free = !m_valid_q || m_axis_tready;

  psched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_op_i    (s_axis_tuser),
    .out_free_i  (out_free),
    .status_i    (status),
    .cmd_o       (cmd),
    .req_ready_o (s_axis_tready)
  );

  psched_datapath #(
    .TASK_SLOTS           (TASK_SLOTS),
    .STRIDE_FRACTION_BITS (STRIDE_FRACTION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_op_i     (s_axis_tuser),
    .req_slot_i   (req_slot),
    .req_budget_i (req_budget),
    .req_period_i (req_period),
    .req_weight_i (req_weight),
    .res_ran_o    (res_ran),
    .res_slot_o   (res_slot),
    .res_pass_o   (res_pass)
  );

  // hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      m_ran_q  <= res_ran;
      m_slot_q <= res_slot;
      m_pass_q <= res_pass;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ran_q;
  assign m_axis_tdata  = {{(psched_pkg::M_TDATA_W - SW - PW){1'b0}}, m_pass_q, m_slot_q};

endmodule

// ===== tb/sv/psched_grant_checker.sv =====
// Watches both channels of the stride scheduler, predicts every tick grant and compares it.
module psched_grant_checker #(
  parameter int unsigned TASK_SLOTS           = 8,
  parameter int unsigned STRIDE_FRACTION_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [psched_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [psched_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tuser,
  output int unsigned                      mismatches_o,
  output int unsigned                      pending_o
);
  import psched_pkg::*;

  localparam int unsigned STRIDE_W = NUMERATOR_W + STRIDE_FRACTION_BITS;

  typedef struct packed {
    logic                    ran;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PASS_W-1:0]       pass;
  } grant_t;

  // own copy of the slot store
  logic                slot_live   [TASK_SLOTS];
  logic [FIELD_W-1:0]  budget_full [TASK_SLOTS];
  logic [FIELD_W-1:0]  period_len  [TASK_SLOTS];
  logic [STRIDE_W-1:0] stride_amt  [TASK_SLOTS];
  logic [FIELD_W-1:0]  budget_rem  [TASK_SLOTS];
  logic [FIELD_W-1:0]  phase_ctr   [TASK_SLOTS];
  logic [PASS_W-1:0]   pass_acc    [TASK_SLOTS];

  grant_t      expected_grants[$];
  grant_t      got;
  grant_t      want;
  int unsigned bad;

  function automatic void capture_task_slot(input logic [SLOT_FIELD_W-1:0] slot,
                                            input logic [FIELD_W-1:0] budget,
                                            input logic [FIELD_W-1:0] period,
                                            input logic [FIELD_W-1:0] weight);
    logic [PASS_W-1:0] numer;
    numer = PASS_W'(STRIDE_NUMERATOR) << STRIDE_FRACTION_BITS;
    // drop loads aimed past the last slot
    if (slot < TASK_SLOTS) begin
      budget_full[slot] = budget;
      period_len[slot]  = period;
      stride_amt[slot]  = (weight != '0) ? STRIDE_W'(numer / weight) : '0;
      slot_live[slot]   = (weight != '0) && (period != '0);
      budget_rem[slot]  = '0;
      phase_ctr[slot]   = '0;
      pass_acc[slot]    = '0;
    end
  endfunction

  function automatic grant_t schedule_tick();
    int                pick;
    logic [PASS_W-1:0] best;
    logic [PASS_W-1:0] room;
    grant_t            g;
    pick = -1;
    best = '0;
    g    = '0;
    // release slots at the start of their period
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (slot_live[i] && phase_ctr[i] == '0) budget_rem[i] = budget_full[i];
    end
    // lowest pass wins, ties go to the lower slot
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (slot_live[i] && budget_rem[i] != '0 && (pick < 0 || pass_acc[i] < best)) begin
        pick = i;
        best = pass_acc[i];
      end
    end
    if (pick >= 0) begin
      g.ran  = 1'b1;
      g.slot = SLOT_FIELD_W'(pick);
      g.pass = best;
      budget_rem[pick] = budget_rem[pick] - 1'b1;
      room = PASS_MAX - pass_acc[pick];
      // hold pass at the ceiling
      if (PASS_W'(stride_amt[pick]) >= room) pass_acc[pick] = PASS_MAX;
      else pass_acc[pick] = pass_acc[pick] + PASS_W'(stride_amt[pick]);
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (slot_live[i]) begin
        if ({1'b0, phase_ctr[i]} + 17'd1 >= {1'b0, period_len[i]}) phase_ctr[i] = '0;
        else phase_ctr[i] = phase_ctr[i] + 1'b1;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        budget_rem[i] = '0;
        phase_ctr[i]  = '0;
        pass_acc[i]   = '0;
      end
      expected_grants.delete();
      bad = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ran  = m_axis_tuser;
        got.slot = m_axis_tdata[SLOT_FIELD_W-1:0];
        got.pass = m_axis_tdata[SLOT_FIELD_W +: PASS_W];
        if (expected_grants.size() == 0) begin
          if (bad < 10)
            $display("unexpected grant at %0t: ran=%0b slot=%0d pass=%h",
                     $time, got.ran, got.slot, got.pass);
          bad++;
        end else begin
          want = expected_grants.pop_front();
          if (got.ran !== want.ran || got.slot !== want.slot || got.pass !== want.pass) begin
            // ran/slot/pass, expected then actual
            if (bad < 10)
              $display("grant mismatch at %0t: expected %0b/%0d/%h, got %0b/%0d/%h",
                       $time, want.ran, want.slot, want.pass, got.ran, got.slot, got.pass);
            bad++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD)
          capture_task_slot(s_axis_tdata[2:0], s_axis_tdata[18:3], s_axis_tdata[34:19],
                            s_axis_tdata[50:35]);
        else
          expected_grants.push_back(schedule_tick());
      end
      mismatches_o <= bad;
      pending_o    <= expected_grants.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Stimulus and verdict for the periodic stride scheduler, with the grant checker beside it.
module tb;
  import psched_pkg::*;

  localparam int unsigned TASK_SLOTS      = 8;
  localparam int unsigned FRACTION_BITS   = 8;
  localparam int unsigned RANDOM_REQUESTS = 1625;
  localparam int unsigned CALM_TAIL       = 150;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned SETTLE_CYCLES   = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles = 0;
  logic        calm = 1'b0;
  int unsigned gap_pct = 20;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  periodic_stride_scheduler #(
    .TASK_SLOTS           (TASK_SLOTS),
    .STRIDE_FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  psched_grant_checker #(
    .TASK_SLOTS           (TASK_SLOTS),
    .STRIDE_FRACTION_BITS (FRACTION_BITS)
  ) grant_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: stall in bursts, hold ready high once calm
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  // Call at a falling edge; returns at a falling edge after acceptance and any gap.
  task automatic push_request(input logic op, input logic [2:0] slot,
                              input logic [15:0] budget, input logic [15:0] period,
                              input logic [15:0] weight);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {{(S_TDATA_W-51){1'b0}}, weight, period, budget, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic tick_request();
    push_request(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // hold requests until every grant has come back
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly short periods and small budgets so slots release and compete often
  task automatic random_load();
    logic [15:0] budget;
    logic [15:0] period;
    logic [15:0] weight;
    case ($urandom_range(0, 9))
      0:       weight = '0;
      1:       weight = 16'($urandom);
      default: weight = 16'($urandom_range(1, 600));
    endcase
    case ($urandom_range(0, 11))
      0:       period = '0;
      1:       period = 16'($urandom);
      default: period = 16'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 9))
      0:       budget = '0;
      1:       budget = 16'($urandom);
      default: budget = 16'($urandom_range(1, 6));
    endcase
    push_request(OP_LOAD, 3'($urandom_range(0, TASK_SLOTS - 1)), budget, period, weight);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle tick with nothing loaded
    tick_request();
    // largest stride against smallest, plus all-ones fields
    push_request(OP_LOAD, 3'd0, 16'd3, 16'd4, 16'd1);
    push_request(OP_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero budget: released but never runs
    push_request(OP_LOAD, 3'd1, 16'd0, 16'd2, 16'd100);
    // zero period and zero weight leave the slot disabled
    push_request(OP_LOAD, 3'd2, 16'd2, 16'd0, 16'd50);
    push_request(OP_LOAD, 3'd3, 16'd1, 16'd1, 16'd0);
    // same stride as slot 0, so equal passes tie
    push_request(OP_LOAD, 3'd4, 16'd2, 16'd3, 16'd1);
    repeat (13) tick_request();
    // reload clears pass, budget and phase
    push_request(OP_LOAD, 3'd0, 16'd2, 16'd5, 16'd2);
    repeat (3) tick_request();
    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (n == RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      if (n % 500 == 250) drain_results();
      if ($urandom_range(0, 7) == 0) random_load();
      else tick_request();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
